[src/sct_pkg.sv]
`default_nettype none
package sct_pkg;

    localparam int COLUMNS  = 256;
    localparam int IDX_W    = $clog2(COLUMNS);
    localparam int HEIGHT_W = 16;
    localparam int COORD_W  = 9;
    localparam int KIND_W   = 2;

    localparam logic [KIND_W-1:0] KIND_INTERIOR = 2'd0;
    localparam logic [KIND_W-1:0] KIND_START    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_END      = 2'd2;

    localparam logic CMD_ADD   = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef struct packed {
        logic [HEIGHT_W-1:0] top;
        logic [HEIGHT_W-1:0] second;
        logic [KIND_W-1:0]   kind;
    } col_entry_t;

    // controller -> datapath
    typedef struct packed {
        logic load;       // capture the incoming item
        logic rd_walk;    // read the next column of an add span
        logic rd_query;   // read the queried column
        logic out_load;   // load the result register
    } sct_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic in_add_ok;  // incoming add has a legal, non-empty span
        logic in_query;   // incoming item is a query
        logic walk_last;  // current read address is the right edge
        logic out_free;   // result register can take a new item
    } sct_stat_t;

endpackage
`default_nettype wire

[src/sct_ctrl.sv]
`default_nettype none
module sct_ctrl
    import sct_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire sct_stat_t stat,
    output sct_cmd_t       cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_WALK  = 2'd1;
    localparam logic [1:0] ST_QREAD = 2'd2;
    localparam logic [1:0] ST_QRESP = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       accept;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        cmd.load     = accept;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (stat.in_query) begin
                        state_next = ST_QREAD;
                    end else if (stat.in_add_ok) begin
                        state_next = ST_WALK;
                    end
                end
            end
            ST_WALK: begin
                cmd.rd_walk = 1'b1;
                if (stat.walk_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_QREAD: begin
                cmd.rd_query = 1'b1;
                state_next   = ST_QRESP;
            end
            ST_QRESP: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

[src/sct_datapath.sv]
`default_nettype none
module sct_datapath
    import sct_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire sct_cmd_t            cmd,
    output sct_stat_t                stat,
    input  wire logic                in_query,
    input  wire logic [COORD_W-1:0]  in_left,
    input  wire logic [COORD_W-1:0]  in_right,
    input  wire logic [HEIGHT_W-1:0] in_height,
    input  wire logic [COORD_W-1:0]  in_column,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic                     out_is_point,
    output logic [COORD_W-1:0]       out_coord,
    output logic [HEIGHT_W-1:0]      out_height
);

    col_entry_t           mem [COLUMNS];
    logic [COLUMNS-1:0]   vld_reg;

    logic [IDX_W-1:0]     lo_reg;
    logic [IDX_W-1:0]     hi_reg;
    logic [HEIGHT_W-1:0]  h_reg;
    logic [COORD_W-1:0]   col_reg;
    logic                 col_ok_reg;
    logic [IDX_W-1:0]     addr_reg;

    col_entry_t           rd_data_reg;
    logic                 rd_vld_reg;
    logic                 wr_pend_reg;
    logic [IDX_W-1:0]     wr_addr_reg;

    logic                 out_valid_reg;
    logic                 out_is_point_reg;
    logic [COORD_W-1:0]   out_coord_reg;
    logic [HEIGHT_W-1:0]  out_height_reg;

    logic                 left_ok;
    logic                 right_ok;
    logic                 col_ok;
    col_entry_t           cur;
    col_entry_t           upd;
    logic                 q_point;
    logic [HEIGHT_W-1:0]  q_height;

    // incoming item checks
    assign left_ok  = (in_left != '0) && (32'(in_left) <= 32'(COLUMNS));
    assign right_ok = (in_right != '0) && (32'(in_right) <= 32'(COLUMNS));
    assign col_ok   = (in_column != '0) && (32'(in_column) <= 32'(COLUMNS));

    assign stat.in_query  = (in_query == CMD_QUERY);
    assign stat.in_add_ok = left_ok && right_ok && (in_left <= in_right);
    assign stat.walk_last = (addr_reg == hi_reg);
    assign stat.out_free  = !out_valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            lo_reg     <= IDX_W'(in_left - 9'd1);
            hi_reg     <= IDX_W'(in_right - 9'd1);
            h_reg      <= in_height;
            col_reg    <= in_column;
            col_ok_reg <= col_ok;
            if (in_query == CMD_QUERY) begin
                addr_reg <= IDX_W'(in_column - 9'd1);
            end else begin
                addr_reg <= IDX_W'(in_left - 9'd1);
            end
        end else if (cmd.rd_walk) begin
            addr_reg <= addr_reg + 1'b1;
        end
    end

    // table read, one column per cycle
    always_ff @(posedge aclk) begin
        if (cmd.rd_walk || cmd.rd_query) begin
            rd_data_reg <= mem[addr_reg];
            rd_vld_reg  <= vld_reg[addr_reg];
            wr_addr_reg <= addr_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_pend_reg <= 1'b0;
        end else begin
            wr_pend_reg <= cmd.rd_walk;
        end
    end

    // an entry never written reads as all zero
    assign cur = rd_vld_reg ? rd_data_reg : '0;

    always_comb begin
        upd = cur;
        priority if (wr_addr_reg == lo_reg) begin
            if (h_reg > cur.top) begin
                upd.top  = h_reg;
                upd.kind = KIND_START;
            end else if (cur.kind == KIND_END && h_reg > cur.second) begin
                upd.second = h_reg;
            end
        end else if (wr_addr_reg == hi_reg) begin
            if (h_reg > cur.top) begin
                upd.top  = h_reg;
                upd.kind = KIND_END;
            end else if (cur.kind == KIND_START && h_reg > cur.second) begin
                upd.second = h_reg;
            end
        end else begin
            if (h_reg > cur.top) begin
                upd.top    = h_reg;
                upd.second = h_reg;
                upd.kind   = KIND_INTERIOR;
            end else if (h_reg < cur.top && h_reg > cur.second &&
                         (cur.kind == KIND_START || cur.kind == KIND_END)) begin
                upd.second = h_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_pend_reg) begin
            mem[wr_addr_reg] <= upd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (wr_pend_reg) begin
            vld_reg[wr_addr_reg] <= 1'b1;
        end
    end

    // query answer
    always_comb begin
        q_point  = 1'b0;
        q_height = '0;
        if (col_ok_reg && cur.top > cur.second) begin
            if (cur.kind == KIND_START) begin
                q_point  = 1'b1;
                q_height = cur.top;
            end else if (cur.kind == KIND_END) begin
                q_point  = 1'b1;
                q_height = cur.second;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_is_point_reg <= q_point;
            out_coord_reg    <= col_reg;
            out_height_reg   <= q_height;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_is_point = out_is_point_reg;
    assign out_coord    = out_coord_reg;
    assign out_height   = out_height_reg;

endmodule
`default_nettype wire

[src/skyline_column_tracker.sv]
`default_nettype none
// Per-column skyline table with add and query commands on one input stream.
// An add walks its span one column per cycle through a pipelined
// read-modify-write of the column table, so it holds the input until the walk
// reaches the right edge; an add with an illegal or empty span is dropped
// without a walk. A query reads its column, then loads the result register
// once that is free, and is answered with one result item; adds give none.
// The table clears at reset through per-column valid bits, so items are taken
// right away. A new item is taken while a result still waits on the output.
module skyline_column_tracker
    import sct_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // left_edge, right_edge, bldg_height, column
    input  wire logic [0:0]  s_tuser,   // cmd
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // point_coord, point_height
    output logic [0:0]       m_tuser    // is_point
);

    sct_cmd_t            cmd;
    sct_stat_t           stat;
    logic                out_is_point;
    logic [COORD_W-1:0]  out_coord;
    logic [HEIGHT_W-1:0] out_height;

    sct_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    sct_datapath u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .stat         (stat),
        .in_query     (s_tuser[0]),
        .in_left      (s_tdata[8:0]),
        .in_right     (s_tdata[17:9]),
        .in_height    (s_tdata[33:18]),
        .in_column    (s_tdata[42:34]),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_is_point (out_is_point),
        .out_coord    (out_coord),
        .out_height   (out_height)
    );

    assign m_tdata = {7'd0, out_height, out_coord};
    assign m_tuser = out_is_point;

endmodule
`default_nettype wire

[bench/testbench.sv]
`timescale 1ns / 1ps

module testbench;
    import sct_pkg::*;

    localparam int ITEM_TARGET = 1500;
    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int DRAIN_CYCLES = 300;   // longest add walk plus query latency

    typedef struct {
        logic        cmd;
        logic [8:0]  left_col;
        logic [8:0]  right_col;
        logic [15:0] height;
        logic [8:0]  column;
    } tracker_item_t;

    typedef struct {
        logic        is_point;
        logic [8:0]  coord;
        logic [15:0] height;
    } skyline_point_t;

    class skyline_scoreboard;
        logic [15:0] top_h    [COLUMNS];
        logic [15:0] second_h [COLUMNS];
        logic [1:0]  kind     [COLUMNS];
        skyline_point_t pending[$];
        int errors;

        function new();
            for (int c = 0; c < COLUMNS; c++) begin
                top_h[c] = '0;
                second_h[c] = '0;
                kind[c] = KIND_INTERIOR;
            end
            errors = 0;
        endfunction

        function void note_item(tracker_item_t it);
            int lo;
            int hi;
            int c;
            skyline_point_t pt;
            if (it.cmd == CMD_ADD) begin
                if (it.left_col == 0 || it.right_col == 0 || it.left_col > COLUMNS ||
                    it.right_col > COLUMNS || it.left_col > it.right_col)
                    return;
                lo = it.left_col - 1;
                hi = it.right_col - 1;
                for (c = lo; c <= hi; c++) begin
                    if (c == lo) begin
                        // single-column buildings only see the start rule
                        if (it.height > top_h[c]) begin
                            top_h[c] = it.height;
                            kind[c] = KIND_START;
                        end else if (kind[c] == KIND_END && it.height > second_h[c]) begin
                            second_h[c] = it.height;
                        end
                    end else if (c == hi) begin
                        if (it.height > top_h[c]) begin
                            top_h[c] = it.height;
                            kind[c] = KIND_END;
                        end else if (kind[c] == KIND_START && it.height > second_h[c]) begin
                            second_h[c] = it.height;
                        end
                    end else begin
                        if (it.height > top_h[c]) begin
                            top_h[c] = it.height;
                            second_h[c] = it.height;
                            kind[c] = KIND_INTERIOR;
                        end else if (it.height < top_h[c] &&
                                     (kind[c] == KIND_START || kind[c] == KIND_END) &&
                                     it.height > second_h[c]) begin
                            second_h[c] = it.height;
                        end
                    end
                end
            end else begin
                pt.is_point = 1'b0;
                pt.coord = it.column;
                pt.height = '0;
                if (it.column >= 1 && it.column <= COLUMNS) begin
                    c = it.column - 1;
                    if (top_h[c] > second_h[c]) begin
                        if (kind[c] == KIND_START) begin
                            pt.is_point = 1'b1;
                            pt.height = top_h[c];
                        end else if (kind[c] == KIND_END) begin
                            pt.is_point = 1'b1;
                            pt.height = second_h[c];
                        end
                    end
                end
                pending.push_back(pt);
            end
        endfunction

        function void check_result(logic is_point, logic [8:0] coord, logic [15:0] height);
            skyline_point_t exp_pt;
            if (pending.size() == 0) begin
                $error("result item with nothing pending: coord %0d", coord);
                errors++;
                return;
            end
            exp_pt = pending.pop_front();
            if (is_point !== exp_pt.is_point) begin
                $error("is_point: expected %0d, got %0d", exp_pt.is_point, is_point);
                errors++;
            end
            if (coord !== exp_pt.coord) begin
                $error("point_coord: expected %0d, got %0d", exp_pt.coord, coord);
                errors++;
            end
            if (height !== exp_pt.height) begin
                $error("point_height: expected %0d, got %0d", exp_pt.height, height);
                errors++;
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;   // left_edge, right_edge, bldg_height, column
    logic [0:0]  s_tuser;   // cmd
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // point_coord, point_height
    logic [0:0]  m_tuser;   // is_point

    skyline_scoreboard sb;
    bit hold_off_req;
    int calm_left;
    int cycles;
    int recent_cols[$];

    skyline_column_tracker uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("skyline_column_tracker regression: fail");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tuser[0], m_tdata[8:0], m_tdata[24:9]);
    end

    // receiver: random stalls, calm stretches, and one-off long hold-offs on request
    initial begin
        int hold;
        int calm;
        int pick;
        hold = 0;
        calm = 0;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                hold = 400;
            end
            if (!aresetn) begin
                m_tready <= 1'b0;
            end else if (hold > 0) begin
                hold--;
                m_tready <= 1'b0;
            end else if (calm > 0) begin
                calm--;
                m_tready <= 1'b1;
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 70) begin
                    m_tready <= 1'b1;
                end else if (pick < 80) begin
                    calm = $urandom_range(20, 200);
                    m_tready <= 1'b1;
                end else if (pick < 97) begin
                    hold = $urandom_range(0, 3);
                    m_tready <= 1'b0;
                end else begin
                    hold = $urandom_range(20, 80);
                    m_tready <= 1'b0;
                end
            end
        end
    end

    function automatic tracker_item_t make_add(int l, int r, int h);
        tracker_item_t it;
        it.cmd = CMD_ADD;
        it.left_col = 9'(l);
        it.right_col = 9'(r);
        it.height = 16'(h);
        it.column = 9'($urandom_range(0, 511));
        return it;
    endfunction

    function automatic tracker_item_t make_query(int col);
        tracker_item_t it;
        it.cmd = CMD_QUERY;
        it.left_col = 9'($urandom_range(0, 511));
        it.right_col = 9'($urandom_range(0, 511));
        it.height = 16'($urandom_range(0, 65535));
        it.column = 9'(col);
        return it;
    endfunction

    // entered right after a rising edge; returns at the edge that takes the item
    task automatic send_item(tracker_item_t it, bit no_gap);
        int gap;
        int pick;
        gap = 0;
        if (!no_gap) begin
            if (calm_left > 0) begin
                calm_left--;
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 60)
                    gap = 0;
                else if (pick < 85)
                    gap = $urandom_range(1, 3);
                else if (pick < 95)
                    gap = $urandom_range(4, 10);
                else if (pick < 98)
                    gap = $urandom_range(20, 60);
                else
                    calm_left = $urandom_range(30, 150);
            end
        end
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.cmd;
        s_tdata  <= {5'd0, it.column, it.height, it.right_col, it.left_col};
        do @(posedge aclk); while (!s_tready);
        sb.note_item(it);
    endtask

    initial begin
        tracker_item_t it;
        int live;
        int pick;
        int l;
        int r;
        int h;
        int col;
        sb = new();
        cycles = 0;
        calm_left = 0;
        hold_off_req = 1'b0;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed
        send_item(make_query(1), 0);            // table after reset
        send_item(make_add(10, 10, 500), 0);    // single column
        send_item(make_query(10), 0);
        send_item(make_add(5, 10, 800), 0);     // right edge overtakes a start
        send_item(make_query(10), 0);
        send_item(make_query(7), 0);
        send_item(make_add(10, 20, 300), 0);    // lower start on an end lifts second
        send_item(make_query(10), 0);
        send_item(make_add(12, 11, 999), 0);    // empty span
        send_item(make_query(11), 0);
        send_item(make_add(0, 5, 1000), 0);     // edges out of range
        send_item(make_add(3, 300, 1000), 0);
        send_item(make_add(257, 257, 1000), 0);
        send_item(make_add(511, 511, 65535), 0);
        send_item(make_query(0), 0);
        send_item(make_query(257), 0);
        send_item(make_query(511), 0);
        send_item(make_add(1, 256, 65535), 0);  // full width, tallest
        send_item(make_query(1), 0);
        send_item(make_query(256), 0);
        send_item(make_query(128), 0);
        send_item(make_add(1, 256, 0), 0);      // zero height under everything
        send_item(make_add(2, 4, 65535), 0);    // equal height
        send_item(make_query(2), 0);
        send_item(make_query(4), 0);

        live = 0;
        while (live < ITEM_TARGET) begin
            if (live == 500 || live == 1100) begin
                // receiver holds off while queries keep coming
                hold_off_req = 1'b1;
                for (int i = 0; i < 40; i++) begin
                    col = (recent_cols.size() > 0 && $urandom_range(0, 1)) ?
                          recent_cols[$urandom_range(0, recent_cols.size() - 1)] :
                          $urandom_range(1, COLUMNS);
                    send_item(make_query(col), 1);
                end
                live += 40;
            end
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                l = $urandom_range(1, COLUMNS);
                pick = $urandom_range(0, 99);
                if (pick < 85)
                    r = l + $urandom_range(0, 7);
                else if (pick < 97)
                    r = l + $urandom_range(8, 64);
                else
                    r = l + $urandom_range(65, 255);
                if (r > COLUMNS)
                    r = COLUMNS;
                // narrow heights make ties and re-hits of the same values
                h = $urandom_range(0, 3) == 0 ? $urandom_range(0, 65535) :
                    $urandom_range(0, 40) * 100;
                send_item(make_add(l, r, h), 0);
                recent_cols.push_back(l);
                recent_cols.push_back(r);
                while (recent_cols.size() > 16)
                    void'(recent_cols.pop_front());
                live++;
            end else if (pick < 50) begin
                it = make_add($urandom_range(0, 511), $urandom_range(0, 511),
                              $urandom_range(0, 65535));
                send_item(it, 0);
                if (it.left_col >= 1 && it.right_col <= COLUMNS && it.left_col <= it.right_col)
                    live++;
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 70 && recent_cols.size() > 0)
                    col = recent_cols[$urandom_range(0, recent_cols.size() - 1)];
                else if (pick < 95)
                    col = $urandom_range(1, COLUMNS);
                else
                    col = $urandom_range(0, 511);
                send_item(make_query(col), 0);
                live++;
            end
        end

        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("skyline_column_tracker regression: pass");
        else
            $display("skyline_column_tracker regression: fail");
        $finish;
    end

endmodule
